### hdl/bpu_pkg.sv
// ----------------------------------------------------------------------------
// bpu_pkg
// Shared widths, codes and defaults of the bilinear pixel upscaler.
// ----------------------------------------------------------------------------
package bpu_pkg;

	localparam int DIM_W      = 13;
	localparam int COORD_W    = 12;
	localparam int SRC_COORD_W = 8;
	localparam int RGB_W      = 24;
	localparam int CH_W       = 8;
	localparam int CH_N       = 3;
	localparam int FRAC_W     = 16;
	localparam int WGT_W      = 8;
	localparam int FIX_SHIFT  = 15;

	localparam int DEF_SRC_WIDTH  = 240;
	localparam int DEF_SRC_HEIGHT = 180;

	localparam logic [DIM_W-1:0] OUT_WIDTH_RST  = DIM_W'(640);
	localparam logic [DIM_W-1:0] OUT_HEIGHT_RST = DIM_W'(480);

	localparam int CFG_IDX_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OUT_WIDTH  = 1'b0,
		CFG_OUT_HEIGHT = 1'b1
	} cfg_idx_t;

	typedef enum logic {
		OP_WRITE   = 1'b0,
		OP_COMPUTE = 1'b1
	} opcode_t;

endpackage

### hdl/bpu_ram.sv
// ----------------------------------------------------------------------------
// bpu_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module bpu_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

### hdl/bpu_div.sv
// ----------------------------------------------------------------------------
// bpu_div
// Two-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bpu_div #(
	parameter int NW = 36,
	parameter int TW = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic [TW-1:0]            in_tag,
	input  logic [NW-1:0]            num_x,
	input  logic [NW-1:0]            num_y,
	input  logic [bpu_pkg::DIM_W-1:0] den_x,
	input  logic [bpu_pkg::DIM_W-1:0] den_y,
	output logic                     out_valid,
	output logic [TW-1:0]            out_tag,
	output logic [NW-1:0]            quo_x,
	output logic [NW-1:0]            quo_y
);
	import bpu_pkg::*;

	// numerator bits shift out at the top while quotient bits shift in below
	logic              v_s   [0:NW];
	logic [TW-1:0]     tag_s [0:NW];
	logic [NW-1:0]     nq_x_s [0:NW];
	logic [NW-1:0]     nq_y_s [0:NW];
	logic [DIM_W-1:0]  r_x_s [0:NW];
	logic [DIM_W-1:0]  r_y_s [0:NW];
	logic [DIM_W-1:0]  d_x_s [0:NW];
	logic [DIM_W-1:0]  d_y_s [0:NW];

	assign v_s[0]    = in_valid;
	assign tag_s[0]  = in_tag;
	assign nq_x_s[0] = num_x;
	assign nq_y_s[0] = num_y;
	assign r_x_s[0]  = '0;
	assign r_y_s[0]  = '0;
	assign d_x_s[0]  = den_x;
	assign d_y_s[0]  = den_y;

	for (genvar i = 0; i < NW; i++) begin : g_stage
		logic [DIM_W:0] tx, ty;
		logic           bx, by;

		always_comb begin
			tx = {r_x_s[i], nq_x_s[i][NW-1]};
			ty = {r_y_s[i], nq_y_s[i][NW-1]};
			bx = tx >= {1'b0, d_x_s[i]};
			by = ty >= {1'b0, d_y_s[i]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			tag_s[i+1]  <= tag_s[i];
			d_x_s[i+1]  <= d_x_s[i];
			d_y_s[i+1]  <= d_y_s[i];
			nq_x_s[i+1] <= {nq_x_s[i][NW-2:0], bx};
			nq_y_s[i+1] <= {nq_y_s[i][NW-2:0], by};
			r_x_s[i+1]  <= bx ? DIM_W'(tx - {1'b0, d_x_s[i]}) : tx[DIM_W-1:0];
			r_y_s[i+1]  <= by ? DIM_W'(ty - {1'b0, d_y_s[i]}) : ty[DIM_W-1:0];
		end
	end

	assign out_valid = v_s[NW];
	assign out_tag   = tag_s[NW];
	assign quo_x     = nq_x_s[NW];
	assign quo_y     = nq_y_s[NW];

endmodule

### hdl/bpu_blend.sv
// ----------------------------------------------------------------------------
// bpu_blend
// Two-stage bilinear blend: horizontal on both rows, then vertical.
// ----------------------------------------------------------------------------
module bpu_blend (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [bpu_pkg::RGB_W-1:0] p00,
	input  logic [bpu_pkg::RGB_W-1:0] p01,
	input  logic [bpu_pkg::RGB_W-1:0] p10,
	input  logic [bpu_pkg::RGB_W-1:0] p11,
	input  logic [bpu_pkg::WGT_W-1:0] wx,
	input  logic [bpu_pkg::WGT_W-1:0] wy,
	output logic                      out_valid,
	output logic [bpu_pkg::RGB_W-1:0] out_rgb
);
	import bpu_pkg::*;

	function automatic logic [RGB_W-1:0] mix(input logic [RGB_W-1:0] a,
			input logic [RGB_W-1:0] b, input logic [WGT_W-1:0] t);
		logic [WGT_W:0]        s;
		logic [2*CH_W:0]       sum;
		logic [RGB_W-1:0]      res;
		s = (WGT_W+1)'(1 << WGT_W) - {1'b0, t};
		res = '0;
		for (int c = 0; c < CH_N; c++) begin
			sum = (2*CH_W+1)'(a[c*CH_W +: CH_W] * s)
				+ (2*CH_W+1)'(b[c*CH_W +: CH_W] * t);
			res[c*CH_W +: CH_W] = sum[WGT_W +: CH_W];
		end
		return res;
	endfunction

	logic              v_s1;
	logic [RGB_W-1:0]  top_s1, bot_s1;
	logic [WGT_W-1:0]  wy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1      <= in_valid;
			out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		top_s1  <= mix(p00, p01, wx);
		bot_s1  <= mix(p10, p11, wx);
		wy_s1   <= wy;
		out_rgb <= mix(top_s1, bot_s1, wy_s1);
	end

endmodule

### hdl/bilinear_pixel_upscaler.sv
// ----------------------------------------------------------------------------
// bilinear_pixel_upscaler
// Bilinear RGB888 upscaler over a stored source image.
// ----------------------------------------------------------------------------
// Usage: raise start with opcode and its fields; busy stays low, so every
// start cycle is a beat. A write beat (opcode write) stores src_rgb at
// (src_x, src_y) and gives no result; writes outside the image are dropped.
// A compute beat maps (out_x, out_y) into source space and gives one
// out_rgb, marked by done for exactly one cycle, in beat order.
// A compute passes stage 1, the bit-per-stage divider, stage C, stage A,
// the image store read and the blend, in that order.
// Throughput is one beat per cycle.
// A write lands in the image at the same pipeline point where a compute
// reads it, so later writes never affect earlier computes.
// cfg_valid/cfg_ready write out_width (index 0) and out_height (index 1);
// write them only with the pipeline empty. Reset sets 640 x 480 and empties
// the pipeline; the image holds no defined data until written.
// The receiver cannot stall: done has no handshake.
// ----------------------------------------------------------------------------
module bilinear_pixel_upscaler #(
	parameter int SRC_WIDTH  = bpu_pkg::DEF_SRC_WIDTH,
	parameter int SRC_HEIGHT = bpu_pkg::DEF_SRC_HEIGHT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            opcode,
	input  logic [bpu_pkg::SRC_COORD_W-1:0] src_x,
	input  logic [bpu_pkg::SRC_COORD_W-1:0] src_y,
	input  logic [bpu_pkg::RGB_W-1:0]       src_rgb,
	input  logic [bpu_pkg::COORD_W-1:0]     out_x,
	input  logic [bpu_pkg::COORD_W-1:0]     out_y,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bpu_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bpu_pkg::DIM_W-1:0]       cfg_data,
	output logic                            done,
	output logic [bpu_pkg::RGB_W-1:0]       out_rgb
);
	import bpu_pkg::*;

	localparam int SRC_MAX = (SRC_WIDTH > SRC_HEIGHT) ? SRC_WIDTH : SRC_HEIGHT;
	localparam int NB    = $clog2(SRC_MAX + 1);
	localparam int PW    = COORD_W + 1 + NB;
	localparam int NW    = PW + FIX_SHIFT;
	localparam int XW    = $clog2(SRC_WIDTH);
	localparam int YW    = $clog2(SRC_HEIGHT);
	localparam int FXW   = XW + FRAC_W;
	localparam int FYW   = YW + FRAC_W;
	localparam int DEPTH = SRC_WIDTH * SRC_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int TW    = 2 + AW + RGB_W;

	localparam logic [NW-1:0] HALF_FIX = NW'(1) << FIX_SHIFT;
	localparam logic [NW-1:0] TOP_X    = NW'(SRC_WIDTH - 1) << FRAC_W;
	localparam logic [NW-1:0] TOP_Y    = NW'(SRC_HEIGHT - 1) << FRAC_W;

	logic [DIM_W-1:0] out_width_q, out_height_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_width_q  <= OUT_WIDTH_RST;
			out_height_q <= OUT_HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_OUT_WIDTH:  out_width_q  <= cfg_data;
				CFG_OUT_HEIGHT: out_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---- stage 1: numerators, divisors and write address
	logic              v_s1;
	logic [NW-1:0]     num_x_s1, num_y_s1;
	logic [DIM_W-1:0]  den_x_s1, den_y_s1;
	logic [TW-1:0]     tag_s1;
	logic [PW-1:0]     prod_x, prod_y;
	logic              wr_ok;
	logic [AW-1:0]     wr_addr;

	always_comb begin
		prod_x  = PW'({out_x, 1'b1}) * PW'(SRC_WIDTH);
		prod_y  = PW'({out_y, 1'b1}) * PW'(SRC_HEIGHT);
		wr_ok   = (opcode == OP_WRITE) && (int'(src_x) < SRC_WIDTH)
			&& (int'(src_y) < SRC_HEIGHT);
		wr_addr = AW'(AW'(src_y) * AW'(SRC_WIDTH) + AW'(src_x));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		num_x_s1 <= {prod_x, FIX_SHIFT'(0)};
		num_y_s1 <= {prod_y, FIX_SHIFT'(0)};
		den_x_s1 <= (out_width_q == '0) ? DIM_W'(1) : out_width_q;
		den_y_s1 <= (out_height_q == '0) ? DIM_W'(1) : out_height_q;
		tag_s1   <= {opcode == OP_COMPUTE, wr_ok, wr_addr, src_rgb};
	end

	// ---- divider
	logic              v_dv;
	logic [TW-1:0]     tag_dv;
	logic [NW-1:0]     quo_x, quo_y;

	bpu_div #(
		.NW(NW),
		.TW(TW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s1),
		.in_tag   (tag_s1),
		.num_x    (num_x_s1),
		.num_y    (num_y_s1),
		.den_x    (den_x_s1),
		.den_y    (den_y_s1),
		.out_valid(v_dv),
		.out_tag  (tag_dv),
		.quo_x    (quo_x),
		.quo_y    (quo_y)
	);

	// ---- stage C: remove half pixel, clamp to the image
	logic              v_sc;
	logic [TW-1:0]     tag_sc;
	logic [FXW-1:0]    fx_sc;
	logic [FYW-1:0]    fy_sc;
	logic [NW-1:0]     qx_m, qy_m;

	always_comb begin
		qx_m = (quo_x < HALF_FIX) ? '0 : quo_x - HALF_FIX;
		qy_m = (quo_y < HALF_FIX) ? '0 : quo_y - HALF_FIX;
		if (qx_m > TOP_X) qx_m = TOP_X;
		if (qy_m > TOP_Y) qy_m = TOP_Y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sc <= 1'b0;
		end else begin
			v_sc <= v_dv;
		end
	end

	always_ff @(posedge clk) begin
		tag_sc <= tag_dv;
		fx_sc  <= qx_m[FXW-1:0];
		fy_sc  <= qy_m[FYW-1:0];
	end

	// ---- stage A: neighbour addresses; writes land here too
	logic              rd_s2, we_s2;
	logic [AW-1:0]     wa_s2;
	logic [RGB_W-1:0]  wd_s2;
	logic [AW-1:0]     a00_s2, a01_s2, a10_s2, a11_s2;
	logic [WGT_W-1:0]  wx_s2, wy_s2;
	logic [XW-1:0]     x0, x1;
	logic [YW-1:0]     y0, y1;
	logic [AW-1:0]     row0, row1;

	always_comb begin
		x0   = fx_sc[FXW-1:FRAC_W];
		y0   = fy_sc[FYW-1:FRAC_W];
		x1   = (int'(x0) + 1 < SRC_WIDTH) ? XW'(x0 + 1'b1) : x0;
		y1   = (int'(y0) + 1 < SRC_HEIGHT) ? YW'(y0 + 1'b1) : y0;
		row0 = AW'(AW'(y0) * AW'(SRC_WIDTH));
		row1 = AW'(AW'(y1) * AW'(SRC_WIDTH));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s2 <= 1'b0;
			we_s2 <= 1'b0;
		end else begin
			rd_s2 <= v_sc && tag_sc[TW-1];
			we_s2 <= v_sc && tag_sc[TW-2];
		end
	end

	always_ff @(posedge clk) begin
		wa_s2  <= tag_sc[RGB_W +: AW];
		wd_s2  <= tag_sc[RGB_W-1:0];
		a00_s2 <= AW'(row0 + AW'(x0));
		a01_s2 <= AW'(row0 + AW'(x1));
		a10_s2 <= AW'(row1 + AW'(x0));
		a11_s2 <= AW'(row1 + AW'(x1));
		wx_s2  <= fx_sc[FRAC_W-1 -: WGT_W];
		wy_s2  <= fy_sc[FRAC_W-1 -: WGT_W];
	end

	// ---- image store: one copy per source row of the cell
	logic [RGB_W-1:0]  p00, p01, p10, p11;
	logic              rd_s3;
	logic [WGT_W-1:0]  wx_s3, wy_s3;

	bpu_ram #(
		.WIDTH(RGB_W),
		.DEPTH(DEPTH)
	) u_ram_row0 (
		.clk    (clk),
		.we     (we_s2),
		.waddr  (wa_s2),
		.wdata  (wd_s2),
		.raddr_a(a00_s2),
		.raddr_b(a01_s2),
		.rdata_a(p00),
		.rdata_b(p01)
	);

	bpu_ram #(
		.WIDTH(RGB_W),
		.DEPTH(DEPTH)
	) u_ram_row1 (
		.clk    (clk),
		.we     (we_s2),
		.waddr  (wa_s2),
		.wdata  (wd_s2),
		.raddr_a(a10_s2),
		.raddr_b(a11_s2),
		.rdata_a(p10),
		.rdata_b(p11)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s3 <= 1'b0;
		end else begin
			rd_s3 <= rd_s2;
		end
	end

	always_ff @(posedge clk) begin
		wx_s3 <= wx_s2;
		wy_s3 <= wy_s2;
	end

	bpu_blend u_blend (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rd_s3),
		.p00      (p00),
		.p01      (p01),
		.p10      (p10),
		.p11      (p11),
		.wx       (wx_s3),
		.wy       (wy_s3),
		.out_valid(done),
		.out_rgb  (out_rgb)
	);

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bilinear pixel upscaler: loads part of the
// source image, issues directed and random write/compute beats under several
// settings of the output size and idle patterns, and compares every out_rgb
// against a bilinear predictor kept alongside the block.
// ----------------------------------------------------------------------------
module tb;
	import bpu_pkg::*;

	localparam int SW      = DEF_SRC_WIDTH;
	localparam int SH      = DEF_SRC_HEIGHT;
	localparam int LATENCY = 42;
	localparam int FILL_W  = 20;
	localparam int FILL_H  = 16;
	localparam int TRIES   = 500;

	typedef int unsigned quad_t [4];

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic                   busy;
	logic                   opcode = OP_WRITE;
	logic [SRC_COORD_W-1:0] src_x = '0;
	logic [SRC_COORD_W-1:0] src_y = '0;
	logic [RGB_W-1:0]       src_rgb = '0;
	logic [COORD_W-1:0]     out_x = '0;
	logic [COORD_W-1:0]     out_y = '0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [DIM_W-1:0]       cfg_data = '0;
	logic                   done;
	logic [RGB_W-1:0]       out_rgb;

	// predictor state
	logic [RGB_W-1:0] image_px [0:SW*SH-1];
	bit               written_px [0:SW*SH-1];
	logic [DIM_W-1:0] width_q = OUT_WIDTH_RST;
	logic [DIM_W-1:0] height_q = OUT_HEIGHT_RST;
	logic [RGB_W-1:0] rgb_due [$];
	int               fails = 0;
	int               idle_pct = 0;

	bilinear_pixel_upscaler i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .opcode(opcode),
		.src_x(src_x), .src_y(src_y), .src_rgb(src_rgb), .out_x(out_x), .out_y(out_y),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done), .out_rgb(out_rgb)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("tb NOT OK");
		$finish;
	end

	// 16.16 source position of an output pixel centre, clamped to the image
	function automatic longint unsigned src_pos(longint unsigned c, longint unsigned n,
			logic [DIM_W-1:0] dim);
		longint unsigned d, q, top;
		d = (dim == 0) ? 1 : dim;
		q = (((2 * c + 1) * n) << 15) / d;
		top = (n - 1) << 16;
		q = (q < 32768) ? 0 : q - 32768;
		return (q > top) ? top : q;
	endfunction

	function automatic logic [RGB_W-1:0] mix_rgb(logic [RGB_W-1:0] a, logic [RGB_W-1:0] b,
			int unsigned t);
		logic [RGB_W-1:0] r;
		int unsigned      v;
		for (int ch = 0; ch < CH_N; ch++) begin
			v = (a[CH_W*ch +: CH_W] * (256 - t) + b[CH_W*ch +: CH_W] * t) >> 8;
			r[CH_W*ch +: CH_W] = v[CH_W-1:0];
		end
		return r;
	endfunction

	// image addresses of the four neighbours an output pixel reads
	function automatic quad_t cell_quad(int unsigned ox, int unsigned oy);
		longint unsigned fx, fy;
		int unsigned     x0, x1, y0, y1;
		quad_t           q;
		fx = src_pos(ox, SW, width_q);
		fy = src_pos(oy, SH, height_q);
		x0 = 32'(fx >> 16);
		y0 = 32'(fy >> 16);
		x1 = (x0 + 1 < SW) ? x0 + 1 : x0;
		y1 = (y0 + 1 < SH) ? y0 + 1 : y0;
		q[0] = y0*SW + x0;
		q[1] = y0*SW + x1;
		q[2] = y1*SW + x0;
		q[3] = y1*SW + x1;
		return q;
	endfunction

	function automatic bit cell_ready(int unsigned ox, int unsigned oy);
		quad_t q;
		q = cell_quad(ox, oy);
		return written_px[q[0]] && written_px[q[1]] && written_px[q[2]] && written_px[q[3]];
	endfunction

	function automatic logic [RGB_W-1:0] upscale_rgb(int unsigned ox, int unsigned oy);
		longint unsigned fx, fy;
		int unsigned     x0, x1, y0, y1;
		logic [RGB_W-1:0] top, bot;
		fx = src_pos(ox, SW, width_q);
		fy = src_pos(oy, SH, height_q);
		x0 = 32'(fx >> 16);
		y0 = 32'(fy >> 16);
		x1 = (x0 + 1 < SW) ? x0 + 1 : x0;
		y1 = (y0 + 1 < SH) ? y0 + 1 : y0;
		top = mix_rgb(image_px[y0*SW + x0], image_px[y0*SW + x1], 32'((fx >> 8) & 255));
		bot = mix_rgb(image_px[y1*SW + x0], image_px[y1*SW + x1], 32'((fx >> 8) & 255));
		return mix_rgb(top, bot, 32'((fy >> 8) & 255));
	endfunction

	// one beat; start stays high into the next beat unless an idle gap follows
	task automatic send_beat(opcode_t op, int unsigned sx, int unsigned sy,
			logic [RGB_W-1:0] rgb, int unsigned ox, int unsigned oy);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start   <= 1'b1;
		opcode  <= op;
		src_x   <= SRC_COORD_W'(sx);
		src_y   <= SRC_COORD_W'(sy);
		src_rgb <= rgb;
		out_x   <= COORD_W'(ox);
		out_y   <= COORD_W'(oy);
		do @(posedge clk); while (busy);
		if (op == OP_COMPUTE)
			rgb_due.push_back(upscale_rgb(ox, oy));
		else if (sx < SW && sy < SH) begin
			image_px[sy*SW + sx] = rgb;
			written_px[sy*SW + sx] = 1'b1;
		end
	endtask

	// load any neighbour not yet written, then issue the compute beat
	task automatic send_compute(int unsigned sx, int unsigned sy, logic [RGB_W-1:0] rgb,
			int unsigned ox, int unsigned oy);
		quad_t q;
		q = cell_quad(ox, oy);
		for (int k = 0; k < 4; k++)
			if (!written_px[q[k]])
				send_beat(OP_WRITE, q[k] % SW, q[k] / SW, $urandom_range(24'hFFFFFF), 0, 0);
		send_beat(OP_COMPUTE, sx, sy, rgb, ox, oy);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		wait (rgb_due.size() == 0);
		// writes may still be in flight after the last result
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [DIM_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_OUT_WIDTH)
			width_q = val;
		else
			height_q = val;
	endtask

	task automatic set_size(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
		write_reg(CFG_OUT_WIDTH, w);
		write_reg(CFG_OUT_HEIGHT, h);
	endtask

	// result checker; done has no handshake, so every strobe is a beat
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (rgb_due.size() == 0) begin
				$error("out_rgb: no result expected, got %06h", out_rgb);
				fails++;
			end else begin
				if (out_rgb !== rgb_due[0]) begin
					$error("out_rgb: expected %06h, got %06h", rgb_due[0], out_rgb);
					fails++;
				end
				void'(rgb_due.pop_front());
			end
		end
	end

	// load the top-left block and the bottom-right corner; computes load the rest
	task automatic test_fill_image();
		for (int y = 0; y < FILL_H; y++)
			for (int x = 0; x < FILL_W; x++)
				send_beat(OP_WRITE, x, y, $urandom_range(24'hFFFFFF), 0, 0);
		for (int y = SH-2; y < SH; y++)
			for (int x = SW-2; x < SW; x++)
				send_beat(OP_WRITE, x, y, $urandom_range(24'hFFFFFF), 0, 0);
	endtask

	task automatic test_directed();
		send_beat(OP_WRITE, 0, 0, 24'h000000, 0, 0);
		send_beat(OP_WRITE, SW-1, SH-1, 24'hFFFFFF, 0, 0);
		send_beat(OP_WRITE, 1, 0, 24'hFFFFFF, 0, 0);
		send_beat(OP_WRITE, 0, 1, 24'hFF00FF, 0, 0);
		// off-image writes must be dropped
		send_beat(OP_WRITE, SW, 0, 24'h123456, 0, 0);
		send_beat(OP_WRITE, 0, SH, 24'h654321, 0, 0);
		send_beat(OP_WRITE, 255, 255, 24'hABCDEF, 0, 0);
		send_compute(0, 0, 0, 0, 0);
		send_compute(0, 0, 0, 1, 1);
		send_compute(0, 0, 0, 639, 479);
		send_compute(0, 0, 0, 4095, 4095);
		send_compute(255, 255, 24'hFFFFFF, 700, 10);
		drain();
		set_size(0, 0);
		send_compute(0, 0, 0, 0, 0);
		send_compute(0, 0, 0, 4095, 4095);
		drain();
		set_size(8191, 4096);
		send_compute(0, 0, 0, 0, 0);
		send_compute(0, 0, 0, 4095, 4095);
		send_compute(0, 0, 0, 2048, 2047);
		drain();
		set_size(1, 1);
		send_compute(0, 0, 0, 0, 0);
		send_compute(0, 0, 0, 3, 2);
		drain();
	endtask

	task automatic test_random(int n, int pct);
		int unsigned r, ox, oy;
		int          tries;
		idle_pct = pct;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 30)
				send_beat(OP_WRITE, $urandom_range(SW-1), $urandom_range(SH-1),
					$urandom_range(24'hFFFFFF), $urandom_range(4095), $urandom_range(4095));
			else if (r < 38)
				send_beat(OP_WRITE, $urandom_range(255), $urandom_range(255),
					$urandom_range(24'hFFFFFF), $urandom_range(4095), $urandom_range(4095));
			else begin
				// prefer a pixel whose neighbours are already loaded
				tries = 0;
				do begin
					if (r < 85) begin
						ox = $urandom_range((width_q == 0 || width_q > 4096) ? 4095 : width_q - 1);
						oy = $urandom_range((height_q == 0 || height_q > 4096) ? 4095 : height_q - 1);
					end else begin
						ox = $urandom_range(4095);
						oy = $urandom_range(4095);
					end
					tries++;
				end while (!cell_ready(ox, oy) && tries < TRIES);
				send_compute($urandom_range(255), $urandom_range(255),
					$urandom_range(24'hFFFFFF), ox, oy);
			end
		end
		idle_pct = 0;
		drain();
	endtask

	// sender holds off until the pipeline has emptied, then resumes
	task automatic test_pause();
		test_random(20, 0);
		send_compute(0, 0, 0, 5, 5);
		start <= 1'b0;
		@(posedge clk);
		wait (rgb_due.size() == 0);
		test_random(20, 0);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill_image();
		drain();
		test_directed();
		set_size(640, 480);
		test_random(250, 0);
		set_size(4096, 4096);
		test_random(250, 61);
		set_size($urandom_range(1, 4096), $urandom_range(1, 4096));
		test_random(250, 32);
		set_size($urandom_range(1, 300), $urandom_range(1, 200));
		test_random(250, 0);
		test_pause();
		drain();
		if (fails == 0 && rgb_due.size() == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule

### sim.f
hdl/bpu_pkg.sv
hdl/bpu_ram.sv
hdl/bpu_div.sv
hdl/bpu_blend.sv
hdl/bilinear_pixel_upscaler.sv
tb/sv/tb.sv
